// File: rtl/core/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned REQ_W       = 24;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned CSR_INDEX_W = 1;

   // Request kinds.
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_ALLOCATED     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_MEMORY = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FREED         = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NULL_IGNORED  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND     = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAP_BASE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAP_BYTES = 1'b1;

   // One row of the block table.
   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [REQ_W-1:0]  size;
      logic              free;
   } entry_type;

   // Status of the size rounding unit.
   typedef struct packed {
      logic done;
      logic oversize;
   } round_status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_ROUND,
      FSM_SCAN,
      FSM_APPEND
   } fsm_state_type;

endpackage

// File: rtl/core/ffba_round.sv
// Rounds a request size up to a multiple of the alignment in two pipelined steps.
module ffba_round
   import ffba_pkg::*;
#(
   parameter int unsigned ALIGN_BYTES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [REQ_W-1:0] request_bytes,
   output round_status_type status,
   output logic [REQ_W-1:0] rounded_bytes
);

   localparam int unsigned SUM_W   = REQ_W + 1;
   localparam int unsigned SHIFT   = SUM_W + $clog2(ALIGN_BYTES);
   localparam int unsigned RECIP_W = SUM_W + 1;
   localparam int unsigned PROD_W  = SUM_W + RECIP_W;
   // Rounded-up reciprocal of the alignment. For any sum below 2^SUM_W the
   // product shifted right by SHIFT is exactly the quotient.
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_FULL[RECIP_W-1:0];
   localparam logic [SUM_W-1:0]   ALIGN_C = SUM_W'(ALIGN_BYTES);

   logic              stage_ff;
   logic              done_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [SUM_W-1:0]  quot_ff;
   logic [SUM_W-1:0]  quot_in;
   logic [PROD_W-1:0] product;
   logic [SUM_W-1:0]  rounded;

   assign sum_in  = SUM_W'(request_bytes) + SUM_W'(ALIGN_BYTES - 1);
   assign product = PROD_W'(sum_ff) * PROD_W'(RECIP_C);
   assign quot_in = SUM_W'(product >> SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= start;
         done_ff  <= stage_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sum_ff <= sum_in;
      end
      if (stage_ff) begin
         quot_ff <= quot_in;
      end
   end

   // The quotient times the alignment never exceeds the sum, so it fits.
   assign rounded         = quot_ff * ALIGN_C;
   assign rounded_bytes   = rounded[REQ_W-1:0];
   assign status.done     = done_ff;
   assign status.oversize = rounded[SUM_W-1];

endmodule

// File: rtl/core/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator: table memory, scan sequencer and config.
//
// The block serves allocate and free requests over a heap region and keeps a
// table of blocks in creation order in a single-port-write, registered-read
// memory. A request is taken when start is high and busy is low; exactly one
// item comes back for each request, on rsp_payload_address and rsp_status,
// marked by rsp_valid for a single cycle. The receiver cannot stall, so the
// item must be captured in that cycle. A free of the null address answers in
// the cycle after it is taken and leaves busy low. Any other free scans the
// table one entry per cycle and stops at the first match, keeping busy high
// until the match or the end of the table. An allocate first rounds its size
// up to the alignment (a reciprocal multiplication behind one register
// stage), then scans the table, and when no free entry fits it tries to
// append a block at the heap break, answering out of memory when the region
// or the table is full. A size that rounds past the size field is refused
// once rounding is done. The result appears in the first cycle in which busy
// is low again. The scan rate is set by the table memory's one read per cycle.
// Configuration writes are always accepted (csr_ready is tied high) and must
// only be issued while the block is idle. Table entries start unwritten;
// only entries below the fill count are ever checked, so no clearing pass is
// needed after reset.
module first_fit_block_allocator_top
   import ffba_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS   = 64,
   parameter int unsigned HEADER_BYTES = 12,
   parameter int unsigned ALIGN_BYTES  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_kind,
   input  logic [REQ_W-1:0]       req_request_bytes,
   input  logic [ADDR_W-1:0]      req_release_address,
   // Result channel.
   output logic                   rsp_valid,
   output logic [ADDR_W-1:0]      rsp_payload_address,
   output logic [STATUS_W-1:0]    rsp_status,
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]      csr_wdata
);

   // The index must be at least one bit wide even for a one-entry table; the
   // count must be able to hold the table size itself.
   localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned NEED_W = ADDR_W + 2;
   localparam logic [ADDR_W-1:0] HDR_C = ADDR_W'(HEADER_BYTES);
   localparam logic [CNT_W-1:0]  MAX_C = CNT_W'(MAX_BLOCKS);

   fsm_state_type state_ff, state_in;

   logic                 kind_ff, kind_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [REQ_W-1:0]     rounded_ff, rounded_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ADDR_W-1:0]    break_ff, break_in;
   logic [ADDR_W-1:0]    heap_base_ff, heap_base_in;
   logic [ADDR_W-1:0]    heap_bytes_ff, heap_bytes_in;
   logic [CNT_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   // Block table memory.
   entry_type            table_mem [MAX_BLOCKS];
   entry_type            rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   entry_type            wr_data;

   // Rounding unit.
   logic                 round_start;
   round_status_type     round_status;
   logic [REQ_W-1:0]     round_bytes;

   // Datapath helpers.
   logic                 rd_issue;
   logic                 hit;
   logic [ADDR_W-1:0]    hit_payload;
   logic [NEED_W-1:0]    need_bytes;
   logic                 fits;
   logic [ADDR_W-1:0]    new_base;

   ffba_round #(
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_round (
      .clock         (clock),
      .reset         (reset),
      .start         (round_start),
      .request_bytes (req_request_bytes),
      .status        (round_status),
      .rounded_bytes (round_bytes)
   );

   // A scanned entry matches an allocate when it is free and large enough,
   // and a free when its payload address equals the released address.
   assign hit_payload = rd_data_ff.base + HDR_C;
   assign hit = (kind_ff == KIND_ALLOC) ? (rd_data_ff.free && (rd_data_ff.size >= rounded_ff))
                                        : (hit_payload == addr_ff);
   assign rd_issue = (scan_idx_ff < count_ff);

   // The region check uses the full sum, so it cannot wrap.
   assign need_bytes = NEED_W'(break_ff) + NEED_W'(HDR_C) + NEED_W'(rounded_ff);
   assign fits       = (need_bytes <= NEED_W'(heap_bytes_ff)) && (count_ff < MAX_C);
   assign new_base   = heap_base_ff + break_ff;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      rounded_in    = rounded_ff;
      count_in      = count_ff;
      break_in      = break_ff;
      heap_base_in  = heap_base_ff;
      heap_bytes_in = heap_bytes_ff;
      scan_idx_in   = scan_idx_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = scan_idx_ff[IDX_W-1:0];
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = scan_idx_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = chk_idx_ff;
      wr_data       = rd_data_ff;
      round_start   = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_HEAP_BASE:  heap_base_in  = csr_wdata;
            CSR_HEAP_BYTES: heap_bytes_in = csr_wdata;
            default:        heap_base_in  = heap_base_ff;
         endcase
      end

      unique case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               kind_in     = req_kind;
               addr_in     = req_release_address;
               scan_idx_in = '0;
               if (req_kind == KIND_FREE) begin
                  if (req_release_address == '0) begin
                     // A null release is answered at once and changes nothing.
                     rsp_valid_in  = 1'b1;
                     rsp_addr_in   = '0;
                     rsp_status_in = STATUS_NULL_IGNORED;
                  end else begin
                     state_in = FSM_SCAN;
                  end
               end else begin
                  round_start = 1'b1;
                  state_in    = FSM_ROUND;
               end
            end
         end

         FSM_ROUND: begin
            if (round_status.done) begin
               rounded_in = round_bytes;
               if (round_status.oversize) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = STATUS_OUT_OF_MEMORY;
                  state_in      = FSM_IDLE;
               end else begin
                  state_in = FSM_SCAN;
               end
            end
         end

         FSM_SCAN: begin
            // One read is issued per cycle; its data is checked in the next cycle.
            chk_valid_in = rd_issue;
            if (rd_issue) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (chk_valid_ff && hit) begin
               // First match in creation order: update its free mark and stop.
               // The read still in flight is dropped.
               chk_valid_in = 1'b0;
               wr_en        = 1'b1;
               wr_data.free = (kind_ff == KIND_FREE);
               rsp_valid_in = 1'b1;
               if (kind_ff == KIND_ALLOC) begin
                  rsp_addr_in   = hit_payload;
                  rsp_status_in = STATUS_ALLOCATED;
               end else begin
                  rsp_addr_in   = '0;
                  rsp_status_in = STATUS_FREED;
               end
               state_in = FSM_IDLE;
            end else if (!rd_issue) begin
               if (kind_ff == KIND_FREE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = STATUS_NOT_FOUND;
                  state_in      = FSM_IDLE;
               end else begin
                  state_in = FSM_APPEND;
               end
            end
         end

         FSM_APPEND: begin
            rsp_valid_in = 1'b1;
            if (fits) begin
               // New block at the heap break; it is created in use.
               wr_en         = 1'b1;
               wr_addr       = count_ff[IDX_W-1:0];
               wr_data.base  = new_base;
               wr_data.size  = rounded_ff;
               wr_data.free  = 1'b0;
               count_in      = count_ff + 1'b1;
               break_in      = need_bytes[ADDR_W-1:0];
               rsp_addr_in   = new_base + HDR_C;
               rsp_status_in = STATUS_ALLOCATED;
            end else begin
               rsp_addr_in   = '0;
               rsp_status_in = STATUS_OUT_OF_MEMORY;
            end
            state_in = FSM_IDLE;
         end

         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         count_ff      <= '0;
         break_ff      <= '0;
         heap_base_ff  <= 32'h1000_0000;
         heap_bytes_ff <= 32'h0010_0000;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         scan_idx_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         break_ff      <= break_in;
         heap_base_ff  <= heap_base_in;
         heap_bytes_ff <= heap_bytes_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         scan_idx_ff   <= scan_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      rounded_ff    <= rounded_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   assign busy                = (state_ff != FSM_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

endmodule
